### hw/rtl/assert_macros.svh
// assertion macros shared by the tiled shift piece generator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/tssp_pkg.sv
// shared types and constants for the tiled shift piece generator
// no dependencies
package tssp_pkg;

  // tile edge is a power of two
  localparam int TILE_SHIFT = 6;
  localparam int TILE_EDGE  = 1 << TILE_SHIFT;

  localparam int IDX_W   = 16;
  localparam int OFS_W   = 24;
  localparam int DIM_W   = 16;
  localparam int LOC_W   = 6;
  localparam int SIZE_W  = 7;
  localparam int LSZ_W   = TILE_SHIFT + 1;
  localparam int COORD_W = ((IDX_W + TILE_SHIFT > OFS_W) ? IDX_W + TILE_SHIFT : OFS_W) + 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_CANVAS_W,
    REG_CANVAS_H
  } reg_idx_t;

  typedef enum logic {
    CMD_SRC_TO_DST = 1'b0,
    CMD_DST_TO_SRC = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;
    logic [DIM_W-1:0]        canvas_width;
    logic [DIM_W-1:0]        canvas_height;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]      tile;
    logic                  two;
    logic [TILE_SHIFT-1:0] src0;
    logic [TILE_SHIFT-1:0] dst0;
    logic [TILE_SHIFT-1:0] dst1;
    logic [LSZ_W-1:0]      len0;
    logic [LSZ_W-1:0]      len1;
  } axis_desc_t;

  typedef struct packed {
    cmd_t       cmd;
    axis_desc_t x;
    axis_desc_t y;
  } piece_desc_t;

endpackage

### hw/rtl/tiled_surface_shift_piece_generator.sv
// top level: register port, front end, descriptor queue and piece emitter
// depends on tssp_pkg, tssp_front, tssp_queue, tssp_back and assert_macros.svh
//
// An item is taken on any cycle with start high and busy low, one per cycle. It
// yields one to four results, one per cycle on out_valid, last marking its final
// one; a clip that misses the canvas yields none. With the queue empty, the first
// result follows the two front stages, the queue and the emitter's output
// registers. The single result port sets the sustained rate, items following back
// to back. The receiver cannot stall; busy rises only when the two front stages
// and the QUEUE_DEPTH-entry descriptor queue together hold QUEUE_DEPTH items.
`include "assert_macros.svh"
module tiled_surface_shift_piece_generator #(
  parameter int QUEUE_DEPTH = tssp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tssp_pkg::ADDR_W-1:0]         paddr,
  input  logic [tssp_pkg::DATA_W-1:0]         pwdata,
  output logic [tssp_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic signed [tssp_pkg::IDX_W-1:0]   tile_col,
  input  logic signed [tssp_pkg::IDX_W-1:0]   tile_row,
  output logic                                out_valid,
  output logic signed [tssp_pkg::IDX_W-1:0]   out_col,
  output logic signed [tssp_pkg::IDX_W-1:0]   out_row,
  output logic [tssp_pkg::LOC_W-1:0]          src_local_x,
  output logic [tssp_pkg::LOC_W-1:0]          src_local_y,
  output logic [tssp_pkg::LOC_W-1:0]          dst_local_x,
  output logic [tssp_pkg::LOC_W-1:0]          dst_local_y,
  output logic [tssp_pkg::SIZE_W-1:0]         piece_width,
  output logic [tssp_pkg::SIZE_W-1:0]         piece_height,
  output logic                                last
);
  import tssp_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 2;

  cfg_t        cfg;
  reg_idx_t    reg_idx;
  logic        wr_en;
  logic        take;
  logic        push, pop, nonempty;
  piece_desc_t push_data, head;
  logic [1:0]       inflight;
  logic [CNT_W-1:0] qcount;
  logic [SUM_W-1:0] occupancy;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OFFSET_X: cfg.offset_x      <= pwdata[OFS_W-1:0];
        REG_OFFSET_Y: cfg.offset_y      <= pwdata[OFS_W-1:0];
        REG_CANVAS_W: cfg.canvas_width  <= pwdata[DIM_W-1:0];
        REG_CANVAS_H: cfg.canvas_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSET_X: prdata = {{(DATA_W-OFS_W){1'b0}}, cfg.offset_x};
      REG_OFFSET_Y: prdata = {{(DATA_W-OFS_W){1'b0}}, cfg.offset_y};
      REG_CANVAS_W: prdata = {{(DATA_W-DIM_W){1'b0}}, cfg.canvas_width};
      REG_CANVAS_H: prdata = {{(DATA_W-DIM_W){1'b0}}, cfg.canvas_height};
      default:      prdata = '0;
    endcase
  end

  // credit check covers items still in the front stages
  assign occupancy = SUM_W'(qcount) + SUM_W'(inflight);
  assign busy      = occupancy >= SUM_W'(QUEUE_DEPTH);
  assign take      = start && !busy;

  tssp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .cmd       (cmd),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .push      (push),
    .push_data (push_data),
    .inflight  (inflight)
  );

  tssp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty),
    .count     (qcount)
  );

  tssp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (nonempty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_col      (out_col),
    .out_row      (out_row),
    .src_local_x  (src_local_x),
    .src_local_y  (src_local_y),
    .dst_local_x  (dst_local_x),
    .dst_local_y  (dst_local_y),
    .piece_width  (piece_width),
    .piece_height (piece_height),
    .last         (last)
  );

  `ASSERT_IMPLY(a_credit_bound, clk, rst, 1'b1, occupancy <= SUM_W'(QUEUE_DEPTH))

endmodule

### hw/rtl/tssp_front.sv
// front end: clips the tile square to the canvas and builds a piece descriptor
// depends on tssp_pkg
module tssp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  tssp_pkg::cfg_t                      cfg,
  input  logic                                take,
  input  logic                                cmd,
  input  logic signed [tssp_pkg::IDX_W-1:0]   tile_col,
  input  logic signed [tssp_pkg::IDX_W-1:0]   tile_row,
  output logic                                push,
  output tssp_pkg::piece_desc_t               push_data,
  output logic [1:0]                          inflight
);
  import tssp_pkg::*;

  typedef struct packed {
    logic             empty;
    logic [DIM_W-1:0] p0;
    logic [DIM_W-1:0] p1;
  } clip_t;

  function automatic logic signed [COORD_W-1:0] tile_base(input logic signed [IDX_W-1:0] t);
    tile_base = {{(COORD_W-IDX_W-TILE_SHIFT){t[IDX_W-1]}}, t, {TILE_SHIFT{1'b0}}};
  endfunction

  function automatic logic signed [COORD_W-1:0] ofs_ext(input logic signed [OFS_W-1:0] o);
    ofs_ext = {{(COORD_W-OFS_W){o[OFS_W-1]}}, o};
  endfunction

  function automatic clip_t clip(input logic signed [COORD_W-1:0] lo,
                                 input logic signed [COORD_W-1:0] hi,
                                 input logic [DIM_W-1:0] dim);
    logic signed [COORD_W-1:0] dim_ext;
    clip_t r;
    dim_ext = {{(COORD_W-DIM_W){1'b0}}, dim};
    r.empty = (dim == '0) || (lo >= dim_ext) || hi[COORD_W-1];
    r.p0    = lo[COORD_W-1] ? '0 : lo[DIM_W-1:0];
    r.p1    = (hi >= dim_ext) ? dim - 1'b1 : hi[DIM_W-1:0];
    return r;
  endfunction

  function automatic axis_desc_t axis(input logic mode1,
                                      input logic [DIM_W-1:0] p0,
                                      input logic [DIM_W-1:0] p1,
                                      input logic signed [OFS_W-1:0] o);
    logic signed [COORD_W-1:0] add;
    logic signed [COORD_W-1:0] s0;
    logic signed [COORD_W-1:0] s1;
    logic [LSZ_W-1:0]          span;
    axis_desc_t                d;
    add    = mode1 ? ofs_ext(o) : '0;
    s0     = {{(COORD_W-DIM_W){1'b0}}, p0} + add;
    s1     = {{(COORD_W-DIM_W){1'b0}}, p1} + add;
    span   = LSZ_W'(p1 - p0) + 1'b1;
    d.tile = s0[TILE_SHIFT +: IDX_W];
    d.two  = s0[COORD_W-1:TILE_SHIFT] != s1[COORD_W-1:TILE_SHIFT];
    d.src0 = s0[TILE_SHIFT-1:0];
    d.dst0 = p0[TILE_SHIFT-1:0];
    d.len0 = d.two ? LSZ_W'(TILE_EDGE) - {1'b0, s0[TILE_SHIFT-1:0]} : span;
    d.len1 = {1'b0, s1[TILE_SHIFT-1:0]} + 1'b1;
    d.dst1 = d.dst0 + d.len0[TILE_SHIFT-1:0];
    return d;
  endfunction

  // stage 1: raw tile square edges
  logic                      v1;
  cmd_t                      cmd1;
  logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [COORD_W-1:0] base_x, base_y, sub_x, sub_y;

  // stage 2: clipped range in canvas coordinates
  logic                      v2;
  cmd_t                      cmd2;
  logic [DIM_W-1:0]          p0_x, p1_x, p0_y, p1_y;
  clip_t                     clip_x, clip_y;

  assign base_x = tile_base(tile_col);
  assign base_y = tile_base(tile_row);
  assign sub_x  = (cmd_t'(cmd) == CMD_SRC_TO_DST) ? ofs_ext(cfg.offset_x) : '0;
  assign sub_y  = (cmd_t'(cmd) == CMD_SRC_TO_DST) ? ofs_ext(cfg.offset_y) : '0;

  assign clip_x = clip(lo_x, hi_x, cfg.canvas_width);
  assign clip_y = clip(lo_y, hi_y, cfg.canvas_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1 && !clip_x.empty && !clip_y.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd1 <= cmd_t'(cmd);
      lo_x <= base_x - sub_x;
      hi_x <= (base_x | COORD_W'(TILE_EDGE - 1)) - sub_x;
      lo_y <= base_y - sub_y;
      hi_y <= (base_y | COORD_W'(TILE_EDGE - 1)) - sub_y;
    end
    if (v1) begin
      cmd2 <= cmd1;
      p0_x <= clip_x.p0;
      p1_x <= clip_x.p1;
      p0_y <= clip_y.p0;
      p1_y <= clip_y.p1;
    end
  end

  // tile split and piece geometry go straight into the queue
  assign push           = v2;
  assign push_data.cmd  = cmd2;
  assign push_data.x    = axis(cmd2 == CMD_DST_TO_SRC, p0_x, p1_x, cfg.offset_x);
  assign push_data.y    = axis(cmd2 == CMD_DST_TO_SRC, p0_y, p1_y, cfg.offset_y);
  assign inflight       = {1'b0, v1} + {1'b0, v2};

endmodule

### hw/rtl/tssp_queue.sv
// descriptor queue between the front end and the piece emitter
// depends on tssp_pkg and assert_macros.svh
`include "assert_macros.svh"
module tssp_queue #(
  parameter int DEPTH = tssp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  tssp_pkg::piece_desc_t        push_data,
  input  logic                         pop,
  output tssp_pkg::piece_desc_t        head,
  output logic                         nonempty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import tssp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  piece_desc_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count_next;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 1'b1;
    if (pop && !push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign head     = mem[rd_ptr];
  assign nonempty = count != '0;

  `ASSERT_IMPLY(a_no_overflow, clk, rst, push && !pop, count != CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, nonempty)

endmodule

### hw/rtl/tssp_back.sv
// piece emitter: walks the up to four tiles of one descriptor in row-major order
// depends on tssp_pkg and assert_macros.svh
`include "assert_macros.svh"
module tssp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  tssp_pkg::piece_desc_t               head,
  input  logic                                head_valid,
  output logic                                pop,
  output logic                                out_valid,
  output logic signed [tssp_pkg::IDX_W-1:0]   out_col,
  output logic signed [tssp_pkg::IDX_W-1:0]   out_row,
  output logic [tssp_pkg::LOC_W-1:0]          src_local_x,
  output logic [tssp_pkg::LOC_W-1:0]          src_local_y,
  output logic [tssp_pkg::LOC_W-1:0]          dst_local_x,
  output logic [tssp_pkg::LOC_W-1:0]          dst_local_y,
  output logic [tssp_pkg::SIZE_W-1:0]         piece_width,
  output logic [tssp_pkg::SIZE_W-1:0]         piece_height,
  output logic                                last
);
  import tssp_pkg::*;

  piece_desc_t           cur;
  logic                  act, act_next;
  logic                  xi, yi;
  logic                  is_last, mode1;
  logic [TILE_SHIFT-1:0] sx, sy, dx, dy;
  logic [LSZ_W-1:0]      w, h;

  assign is_last  = (xi == cur.x.two) && (yi == cur.y.two);
  assign pop      = head_valid && (!act || is_last);
  assign act_next = pop || (act && !is_last);
  assign mode1    = cur.cmd == CMD_DST_TO_SRC;

  // second column or row starts at the tile edge on the source side
  assign sx = (mode1 && !xi) ? cur.x.src0 : '0;
  assign sy = (mode1 && !yi) ? cur.y.src0 : '0;
  assign dx = !mode1 ? '0 : (xi ? cur.x.dst1 : cur.x.dst0);
  assign dy = !mode1 ? '0 : (yi ? cur.y.dst1 : cur.y.dst0);
  assign w  = !mode1 ? '0 : (xi ? cur.x.len1 : cur.x.len0);
  assign h  = !mode1 ? '0 : (yi ? cur.y.len1 : cur.y.len0);

  always_ff @(posedge clk) begin
    if (rst) begin
      act       <= 1'b0;
      out_valid <= 1'b0;
      xi        <= 1'b0;
      yi        <= 1'b0;
    end else begin
      act       <= act_next;
      out_valid <= act;
      if (pop) begin
        xi <= 1'b0;
        yi <= 1'b0;
      end else if (act) begin
        if (xi != cur.x.two) begin
          xi <= 1'b1;
        end else begin
          xi <= 1'b0;
          yi <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (act) begin
      out_col      <= cur.x.tile + {{(IDX_W-1){1'b0}}, xi};
      out_row      <= cur.y.tile + {{(IDX_W-1){1'b0}}, yi};
      src_local_x  <= LOC_W'(sx);
      src_local_y  <= LOC_W'(sy);
      dst_local_x  <= LOC_W'(dx);
      dst_local_y  <= LOC_W'(dy);
      piece_width  <= SIZE_W'(w);
      piece_height <= SIZE_W'(h);
      last         <= is_last;
    end
  end

  `ASSERT_NEXT(a_item_continues, clk, rst, act && !is_last, act && (xi || yi))

endmodule
